// ===== rtl/krt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants for the keyed record table
// Holds the record layout, request and status codes, and controller states.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int KEY_W   = 16;
  localparam int AGE_W   = 8;
  localparam int MARK_W  = 14;
  localparam int COUNT_W = 7;
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;

  // Highest mark in hundredths; larger inputs saturate here
  localparam logic [MARK_W-1:0] MARK_MAX = 14'd10000;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [AGE_W-1:0]  age;
    logic [MARK_W-1:0] mark;
  } record_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 3'd0,
    REQ_LOOKUP = 3'd1,
    REQ_UPDATE = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_LIST   = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/krt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// krt_cell: one storage cell of the record chain
// Holds a single record and loads its input record (its neighbor's, or the feedback record at the tail) on each shift.
// ----------------------------------------------------------------------------
module krt_cell (
  input  wire              clk,
  input  wire              shift_en,
  input  wire krt_pkg::record_t rec_in,
  output krt_pkg::record_t rec_out
);
  import krt_pkg::*;

  record_t rec_r;

  // Payload only, no reset needed
  always_ff @(posedge clk) begin
    if (shift_en) begin
      rec_r <= rec_in;
    end
  end

  assign rec_out = rec_r;

endmodule
`default_nettype wire

// ===== rtl/keyed_record_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_record_table: unsorted record table with linear search
// Records sit in a rotating chain of cells. Every request rotates the chain
// once around; the head cell is examined, and the record fed back into the
// tail is chosen to insert, update or close a gap.
// ----------------------------------------------------------------------------
//  channel  | ports                                          | direction
//  ---------+------------------------------------------------+----------
//  request  | in_valid, in_stall, in_req_type, in_key,        | in
//           | in_age_in, in_mark_in                           |
//  result   | out_valid, out_stall, out_status, out_key_out,  | out
//           | out_age_out, out_mark_out, out_last, out_count_out |
//
// Each request makes one full rotation of the cell chain after acceptance,
// one cell step per cycle while results are taken at once. A list request
// emits one result per stored record, or one STAT_EMPTY result if none, and a
// step waits while the output register holds a result that is stalled.
// Request codes 5 to 7 are accepted and dropped. Reset clears the record
// count and the controller; cell contents are don't-care until written.
// ----------------------------------------------------------------------------
module keyed_record_table #(
  parameter int CAPACITY = 64
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [krt_pkg::REQ_W-1:0]         in_req_type,
  input  wire  [krt_pkg::KEY_W-1:0]         in_key,
  input  wire  [krt_pkg::AGE_W-1:0]         in_age_in,
  input  wire  [krt_pkg::MARK_W-1:0]        in_mark_in,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [krt_pkg::STAT_W-1:0]        out_status,
  output logic [krt_pkg::KEY_W-1:0]         out_key_out,
  output logic [krt_pkg::AGE_W-1:0]         out_age_out,
  output logic [krt_pkg::MARK_W-1:0]        out_mark_out,
  output logic                              out_last,
  output logic [krt_pkg::COUNT_W-1:0]       out_count_out
);
  import krt_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NEXT_CELL = 1 % CAPACITY;
  localparam logic [IDX_W-1:0]   LAST_STEP = IDX_W'(CAPACITY - 1);
  localparam logic [COUNT_W-1:0] CAP_CNT   = COUNT_W'(CAPACITY);

  // Controller state
  state_t               state_r, state_nxt;
  req_t                 op_r;
  logic [KEY_W-1:0]     key_r;
  logic [AGE_W-1:0]     age_r;
  logic [MARK_W-1:0]    mark_r;
  logic [IDX_W-1:0]     step_r;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 found_r;
  record_t              cap_r;

  // Output register
  logic                 out_valid_r;
  status_t              out_status_r;
  record_t              out_rec_r;
  logic                 out_last_r;
  logic [COUNT_W-1:0]   out_count_r;

  // Chain
  record_t              cell_q [CAPACITY];
  record_t              fb_rec;
  record_t              head;
  record_t              new_rec;
  record_t              upd_rec;

  logic                 in_acc;
  logic                 req_ok;
  logic                 out_free;
  logic                 adv;
  logic                 final_step;
  logic                 in_range;
  logic                 hit;
  logic                 found_any;
  logic [COUNT_W-1:0]   step_ext;
  logic [MARK_W-1:0]    mark_sat;

  logic                 emit;
  status_t              emit_status;
  record_t              emit_rec;
  logic                 emit_last;

  // Request decode and mark saturation
  assign in_acc   = in_valid && !in_stall;
  assign mark_sat = (in_mark_in > MARK_MAX) ? MARK_MAX : in_mark_in;

  always_comb begin
    case (req_t'(in_req_type))
      REQ_ADD, REQ_LOOKUP, REQ_UPDATE, REQ_DELETE, REQ_LIST: req_ok = 1'b1;
      default:                                               req_ok = 1'b0;
    endcase
  end

  // Step control
  assign out_free   = !out_valid_r || !out_stall;
  assign adv        = (state_r == ST_SCAN) && out_free;
  assign final_step = adv && (step_r == LAST_STEP);
  assign step_ext   = COUNT_W'(step_r);
  assign in_range   = step_ext < cnt_r;

  assign head      = cell_q[0];
  assign hit       = in_range && !found_r && (head.key == key_r);
  assign found_any = found_r || hit;

  assign new_rec = '{key: key_r, age: age_r, mark: mark_r};
  assign upd_rec = '{key: head.key, age: head.age, mark: mark_r};

  // Record fed back into the tail cell
  always_comb begin
    fb_rec = head;
    case (op_r)
      REQ_ADD: begin
        if ((step_ext == cnt_r) && (cnt_r < CAP_CNT)) fb_rec = new_rec;
      end
      REQ_UPDATE: begin
        if (hit) fb_rec = upd_rec;
      end
      REQ_DELETE: begin
        if (found_any) fb_rec = cell_q[NEXT_CELL];
      end
      default: fb_rec = head;
    endcase
  end

  // Cell chain, rotating toward cell 0
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    record_t cell_d;
    if (j == CAPACITY - 1) begin : g_tail
      assign cell_d = fb_rec;
    end else begin : g_body
      assign cell_d = cell_q[j+1];
    end
    krt_cell u_cell (
      .clk      (clk),
      .shift_en (adv),
      .rec_in   (cell_d),
      .rec_out  (cell_q[j])
    );
  end

  // Count after the request
  always_comb begin
    cnt_nxt = cnt_r;
    case (op_r)
      REQ_ADD: begin
        if (cnt_r < CAP_CNT) cnt_nxt = cnt_r + COUNT_W'(1);
      end
      REQ_DELETE: begin
        if (found_any) cnt_nxt = cnt_r - COUNT_W'(1);
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Result generation
  always_comb begin
    emit        = 1'b0;
    emit_status = STAT_OK;
    emit_rec    = '0;
    emit_last   = 1'b1;
    case (op_r)
      REQ_LIST: begin
        if (adv && in_range) begin
          emit      = 1'b1;
          emit_rec  = head;
          emit_last = (COUNT_W'(step_ext + COUNT_W'(1)) == cnt_r);
        end else if (final_step && (cnt_r == '0)) begin
          emit        = 1'b1;
          emit_status = STAT_EMPTY;
        end
      end
      REQ_ADD: begin
        if (final_step) begin
          emit = 1'b1;
          if (cnt_r < CAP_CNT) begin
            emit_rec = new_rec;
          end else begin
            emit_status = STAT_FULL;
          end
        end
      end
      default: begin
        if (final_step) begin
          emit = 1'b1;
          if (hit) begin
            emit_rec = (op_r == REQ_UPDATE) ? upd_rec : head;
          end else if (found_r) begin
            emit_rec = cap_r;
          end else begin
            emit_status = STAT_NOT_FOUND;
          end
        end
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && req_ok) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (final_step) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_SCAN: in_stall = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        step_r  <= '0;
        found_r <= 1'b0;
      end else if (adv) begin
        step_r <= step_r + IDX_W'(1);
        if (hit) found_r <= 1'b1;
      end
      if (final_step) cnt_r <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= req_t'(in_req_type);
      key_r  <= in_key;
      age_r  <= in_age_in;
      mark_r <= mark_sat;
    end
    if (adv && hit) begin
      cap_r <= (op_r == REQ_UPDATE) ? upd_rec : head;
    end
    if (emit) begin
      out_status_r <= emit_status;
      out_rec_r    <= emit_rec;
      out_last_r   <= emit_last;
      out_count_r  <= (emit_status == STAT_EMPTY) ? '0 :
                      (final_step ? cnt_nxt : cnt_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key_out   = out_rec_r.key;
  assign out_age_out   = out_rec_r.age;
  assign out_mark_out  = out_rec_r.mark;
  assign out_last      = out_last_r;
  assign out_count_out = out_count_r;

endmodule
`default_nettype wire
